### rtl/rgpg_pkg.sv
// shared constants, types and the xorshift step function for the random gate pulse generator
package rgpg_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int PROB_WIDTH   = 15;
   localparam int LEN_WIDTH    = 20;
   localparam int SEED_WIDTH   = 32;
   localparam int FRAC_WIDTH   = 24;
   localparam int CSR_WIDTH    = 32;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [PROB_WIDTH-1:0] Q_ONE        = 15'd16384;
   localparam logic signed [SAMPLE_WIDTH-1:0] HIGH_THRESH = 16'sd11469;
   localparam logic signed [SAMPLE_WIDTH-1:0] LOW_THRESH  = 16'sd4915;
   localparam logic [SEED_WIDTH-1:0] DEFAULT_SEED = 32'd2463534242;
   localparam logic [PROB_WIDTH-1:0] DEFAULT_PROB = 15'd8192;
   localparam logic [LEN_WIDTH-1:0]  DEFAULT_LEN  = 20'd96;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BASE_PROB = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PULSE_LEN = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RNG_SEED  = 2'd2;

   typedef logic [SEED_WIDTH-1:0] rng_word_type;

   function automatic rng_word_type xorshift_next(input rng_word_type s);
      rng_word_type t;
      t = s ^ (s << 13);
      t = t ^ (t >> 17);
      t = t ^ (t << 5);
      return t;
   endfunction

endpackage

### rtl/random_gate_pulse_generator_core.sv
// random gate pulse generator: schmitt clock edge, xorshift32 draw, pulse counter
// the result is registered and valid in the cycle after the input transfer
// throughput: one item per cycle while the output is not stalled; the output register drains while the next item enters
// the whole step (trigger, xorshift advance, 24-bit compare, count) sits before one register
// reset: synchronous, active high; registers but the gate output return to defaults, generator loads default seed
// no clearing pass after reset, the block accepts items on the first cycle after reset
module random_gate_pulse_generator_core
   import rgpg_pkg::*;
#(
   parameter int COUNT_WIDTH = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_clock_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_prob_cv,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_gate,
   input  logic                           csr_write,
   input  logic [CSR_IDX_WIDTH-1:0]       csr_index,
   input  logic [CSR_WIDTH-1:0]           csr_data
);

   localparam logic [32:0] COUNT_MAX_WIDE = (33'd1 << COUNT_WIDTH) - 33'd1;
   localparam logic [31:0] COUNT_MAX      = COUNT_MAX_WIDE[31:0];

   logic [PROB_WIDTH-1:0]  base_prob_ff, base_prob_in;
   logic [LEN_WIDTH-1:0]   pulse_len_ff, pulse_len_in;
   logic                   clock_high_ff, clock_high_in;
   logic [COUNT_WIDTH-1:0] pulse_left_ff, pulse_left_in;
   rng_word_type           rng_state_ff, rng_state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_gate_ff, rsp_gate_in;

   logic                   req_take;
   logic [PROB_WIDTH-1:0]  prob;
   logic                   rise;
   rng_word_type           rng_next;
   logic                   fire;
   logic [31:0]            len_wide;
   logic [31:0]            load_wide;
   logic [COUNT_WIDTH-1:0] count_after;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_gate  = rsp_gate_ff;

   // probability select and clamp
   always_comb begin
      if (req_prob_cv == '0) begin
         prob = (base_prob_ff > Q_ONE) ? Q_ONE : base_prob_ff;
      end else if (req_prob_cv < 0) begin
         prob = '0;
      end else if (req_prob_cv > $signed({1'b0, Q_ONE})) begin
         prob = Q_ONE;
      end else begin
         prob = req_prob_cv[PROB_WIDTH-1:0];
      end
   end

   assign rise     = !clock_high_ff && (req_clock_sample >= HIGH_THRESH);
   assign rng_next = xorshift_next(rng_state_ff);
   assign fire     = rise && ({1'b0, rng_next[SEED_WIDTH-1 -: FRAC_WIDTH]} <= {prob, 10'b0});

   // pulse length with zero and counter saturation
   always_comb begin
      len_wide = {{(32 - LEN_WIDTH){1'b0}}, pulse_len_ff};
      if (len_wide == '0) begin
         load_wide = 32'd1;
      end else if (len_wide > COUNT_MAX) begin
         load_wide = COUNT_MAX;
      end else begin
         load_wide = len_wide;
      end
   end

   assign count_after = fire ? load_wide[COUNT_WIDTH-1:0] : pulse_left_ff;

   always_comb begin
      base_prob_in  = base_prob_ff;
      pulse_len_in  = pulse_len_ff;
      clock_high_in = clock_high_ff;
      pulse_left_in = pulse_left_ff;
      rng_state_in  = rng_state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_gate_in   = rsp_gate_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_gate_in  = (count_after != '0);
         if (count_after != '0) begin
            pulse_left_in = count_after - 1'b1;
         end else begin
            pulse_left_in = count_after;
         end
         if (rise) begin
            clock_high_in = 1'b1;
            rng_state_in  = rng_next;
         end else if (clock_high_ff && (req_clock_sample <= LOW_THRESH)) begin
            clock_high_in = 1'b0;
         end
      end
      if (csr_write) begin
         unique case (csr_index)
            CSR_BASE_PROB: base_prob_in = csr_data[PROB_WIDTH-1:0];
            CSR_PULSE_LEN: pulse_len_in = csr_data[LEN_WIDTH-1:0];
            CSR_RNG_SEED:  rng_state_in = (csr_data != '0) ? csr_data : DEFAULT_SEED;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_prob_ff  <= DEFAULT_PROB;
         pulse_len_ff  <= DEFAULT_LEN;
         clock_high_ff <= 1'b0;
         pulse_left_ff <= '0;
         rng_state_ff  <= DEFAULT_SEED;
         rsp_valid_ff  <= 1'b0;
      end else begin
         base_prob_ff  <= base_prob_in;
         pulse_len_ff  <= pulse_len_in;
         clock_high_ff <= clock_high_in;
         pulse_left_ff <= pulse_left_in;
         rng_state_ff  <= rng_state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_gate_ff <= rsp_gate_in;
   end

endmodule

### rtl/rgpg_checker.sv
// port-level assertions for the random gate pulse generator, bound to the generator core
module rgpg_port_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);

   // a held result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // every input transfer yields a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("input transfer without result");

   // an empty output register never holds off the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind random_gate_pulse_generator_core rgpg_port_checker u_rgpg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);
